>>> rtl/lzbd_pkg.sv
// shared types, constants and helpers for the lz block decompressor
// no dependencies; used by lzbd_history, lzbd_core and lz_block_decompressor

package lzbd_pkg;

	// history depth is a power of two set by its address width (65536 entries)
	localparam int unsigned HIST_AW       = 16;
	localparam int unsigned HISTORY_DEPTH = 1 << HIST_AW;

	typedef logic [HIST_AW-1:0] hist_addr_t;

	// token and length constants
	localparam logic [3:0]  NIBBLE_EXT = 4'hf;
	localparam logic [7:0]  BYTE_EXT   = 8'hff;
	localparam logic [31:0] MIN_MATCH  = 32'd4;
	localparam logic [31:0] MATCH_EXT  = 32'd19;

	typedef enum logic [7:0] {
		PH_TOKEN  = 8'b0000_0001,
		PH_LITLEN = 8'b0000_0010,
		PH_LIT    = 8'b0000_0100,
		PH_OFFLO  = 8'b0000_1000,
		PH_OFFHI  = 8'b0001_0000,
		PH_MATLEN = 8'b0010_0000,
		PH_COPY   = 8'b0100_0000,
		PH_DONE   = 8'b1000_0000
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_REFUSED    = 3'd1,
		ST_BAD_OFFSET = 3'd2,
		ST_TRUNCATED  = 3'd3,
		ST_LIMIT      = 3'd4
	} status_t;

	typedef struct packed {
		logic       en;
		hist_addr_t addr;
		logic [7:0] data;
	} hist_wr_t;

	typedef struct packed {
		logic       en;
		hist_addr_t addr;
	} hist_rd_t;

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       last;
		logic       busy;
		status_t    status;
	} result_t;

	// length extension, saturating at all ones
	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [7:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {25'b0, b};
		return s[32] ? '1 : s[31:0];
	endfunction

endpackage

>>> rtl/lzbd_history.sv
// history memory of decompressed bytes, one write and one registered read port
// read returns the byte written at the same edge when the addresses match
// depends on lzbd_pkg

module lzbd_history (
	input  logic               clk,
	input  lzbd_pkg::hist_wr_t wr,
	input  lzbd_pkg::hist_rd_t rd,
	output logic [7:0]         rd_data
);

	logic [7:0] mem [lzbd_pkg::HISTORY_DEPTH];
	logic [7:0] mem_q;
	logic       byp_q;
	logic [7:0] byp_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			mem_q <= mem[rd.addr];
		end
	end

	// write-to-read forwarding for overlapping copies
	always_ff @(posedge clk) begin
		if (rd.en) begin
			byp_q      <= wr.en && (wr.addr == rd.addr);
			byp_data_q <= wr.data;
		end
	end

	assign rd_data = byp_q ? byp_data_q : mem_q;

endmodule

>>> rtl/lzbd_core.sv
// sequence decoder: parse state, counters and the per-item next-state logic
// drives the history write and the read address for the next item
// depends on lzbd_pkg

module lzbd_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic                 cmd,
	input  logic [7:0]           in_byte,
	input  logic                 in_last,
	input  logic [31:0]          output_limit,
	input  logic [7:0]           rd_data,
	output lzbd_pkg::result_t    res,
	output lzbd_pkg::hist_wr_t   wr,
	output lzbd_pkg::hist_addr_t rd_addr
);

	lzbd_pkg::phase_t ph_q, ph_d;
	logic [31:0] lit_q, lit_d;
	logic [31:0] mat_q, mat_d;
	logic [15:0] dist_q, dist_d;
	logic [31:0] cnt_q, cnt_d;
	logic        end_q, end_d;

	logic [31:0] cnt_tok;
	logic [31:0] cnt_inc;
	logic [15:0] dist_hi;
	logic [31:0] rd_diff;

	always_comb begin
		ph_d    = ph_q;
		lit_d   = lit_q;
		mat_d   = mat_q;
		dist_d  = dist_q;
		cnt_d   = cnt_q;
		end_d   = end_q;
		res     = '0;
		wr.en   = 1'b0;
		wr.addr = cnt_q[lzbd_pkg::HIST_AW-1:0];
		wr.data = in_byte;
		cnt_tok = (ph_q == lzbd_pkg::PH_DONE) ? 32'd0 : cnt_q;
		cnt_inc = cnt_q + 32'd1;
		dist_hi = {in_byte, dist_q[7:0]};

		if (step) begin
			if (!cmd) begin
				unique case (ph_q) inside
					lzbd_pkg::PH_TOKEN, lzbd_pkg::PH_DONE: begin
						// a push after the block ended starts a new block
						cnt_d  = cnt_tok;
						dist_d = (ph_q == lzbd_pkg::PH_DONE) ? 16'd0 : dist_q;
						end_d  = (ph_q == lzbd_pkg::PH_DONE) ? 1'b0 : end_q;
						lit_d  = {28'b0, in_byte[7:4]};
						mat_d  = lzbd_pkg::MIN_MATCH + {28'b0, in_byte[3:0]};
						ph_d   = lzbd_pkg::PH_LIT;
						if (in_byte[7:4] == lzbd_pkg::NIBBLE_EXT) begin
							ph_d = lzbd_pkg::PH_LITLEN;
						end
						if (in_byte[7:4] == 4'd0) begin
							if (in_last || cnt_tok >= output_limit) begin
								ph_d       = lzbd_pkg::PH_DONE;
								res.last   = 1'b1;
								res.status = lzbd_pkg::ST_OK;
							end else begin
								ph_d = lzbd_pkg::PH_OFFLO;
							end
						end else if (in_last) begin
							ph_d       = lzbd_pkg::PH_DONE;
							res.last   = 1'b1;
							res.status = lzbd_pkg::ST_TRUNCATED;
						end
					end
					lzbd_pkg::PH_LITLEN: begin
						lit_d = lzbd_pkg::sat_add(lit_q, in_byte);
						if (in_last) begin
							ph_d       = lzbd_pkg::PH_DONE;
							res.last   = 1'b1;
							res.status = lzbd_pkg::ST_TRUNCATED;
						end else if (in_byte != lzbd_pkg::BYTE_EXT) begin
							ph_d = lzbd_pkg::PH_LIT;
						end
					end
					lzbd_pkg::PH_LIT: begin
						if (cnt_q >= output_limit) begin
							ph_d       = lzbd_pkg::PH_DONE;
							res.last   = 1'b1;
							res.status = lzbd_pkg::ST_LIMIT;
						end else begin
							wr.en     = 1'b1;
							cnt_d     = cnt_inc;
							res.valid = 1'b1;
							res.data  = in_byte;
							lit_d     = lit_q - 32'd1;
							if (lit_q == 32'd1) begin
								if (in_last || cnt_inc >= output_limit) begin
									ph_d     = lzbd_pkg::PH_DONE;
									res.last = 1'b1;
								end else begin
									ph_d = lzbd_pkg::PH_OFFLO;
								end
							end else if (in_last) begin
								ph_d       = lzbd_pkg::PH_DONE;
								res.last   = 1'b1;
								res.status = lzbd_pkg::ST_TRUNCATED;
							end
						end
					end
					lzbd_pkg::PH_OFFLO: begin
						dist_d = {8'b0, in_byte};
						if (in_last) begin
							ph_d       = lzbd_pkg::PH_DONE;
							res.last   = 1'b1;
							res.status = lzbd_pkg::ST_TRUNCATED;
						end else begin
							ph_d = lzbd_pkg::PH_OFFHI;
						end
					end
					lzbd_pkg::PH_OFFHI: begin
						dist_d = dist_hi;
						if (dist_hi == 16'd0 || {16'b0, dist_hi} > cnt_q
							|| {16'b0, dist_hi} > 32'(lzbd_pkg::HISTORY_DEPTH)) begin
							ph_d       = lzbd_pkg::PH_DONE;
							res.last   = 1'b1;
							res.status = lzbd_pkg::ST_BAD_OFFSET;
						end else if (mat_q == lzbd_pkg::MATCH_EXT) begin
							if (in_last) begin
								ph_d       = lzbd_pkg::PH_DONE;
								res.last   = 1'b1;
								res.status = lzbd_pkg::ST_TRUNCATED;
							end else begin
								ph_d = lzbd_pkg::PH_MATLEN;
							end
						end else begin
							ph_d  = lzbd_pkg::PH_COPY;
							end_d = in_last;
						end
					end
					lzbd_pkg::PH_MATLEN: begin
						mat_d = lzbd_pkg::sat_add(mat_q, in_byte);
						if (in_byte != lzbd_pkg::BYTE_EXT) begin
							ph_d  = lzbd_pkg::PH_COPY;
							end_d = in_last;
						end else if (in_last) begin
							ph_d       = lzbd_pkg::PH_DONE;
							res.last   = 1'b1;
							res.status = lzbd_pkg::ST_TRUNCATED;
						end
					end
					lzbd_pkg::PH_COPY: begin
						res.status = lzbd_pkg::ST_REFUSED;
					end
					default: begin
						ph_d = ph_q;
					end
				endcase
			end else if (ph_q == lzbd_pkg::PH_COPY) begin
				if (cnt_q >= output_limit) begin
					ph_d       = lzbd_pkg::PH_DONE;
					res.last   = 1'b1;
					res.status = lzbd_pkg::ST_LIMIT;
				end else begin
					wr.en     = 1'b1;
					wr.data   = rd_data;
					cnt_d     = cnt_inc;
					res.valid = 1'b1;
					res.data  = rd_data;
					mat_d     = mat_q - 32'd1;
					if (mat_q == 32'd1) begin
						if (end_q) begin
							ph_d     = lzbd_pkg::PH_DONE;
							res.last = 1'b1;
						end else begin
							ph_d = lzbd_pkg::PH_TOKEN;
						end
					end
				end
			end
			// finishing clears the run lengths
			if (ph_d == lzbd_pkg::PH_DONE) begin
				lit_d = '0;
				mat_d = '0;
			end
		end
		res.busy = (ph_d == lzbd_pkg::PH_COPY);
	end

	// source of the next copied byte, taken from the state after this item
	assign rd_diff = cnt_d - {16'b0, dist_d};
	assign rd_addr = rd_diff[lzbd_pkg::HIST_AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= lzbd_pkg::PH_TOKEN;
			lit_q  <= '0;
			mat_q  <= '0;
			dist_q <= '0;
			cnt_q  <= '0;
			end_q  <= 1'b0;
		end else begin
			ph_q   <= ph_d;
			lit_q  <= lit_d;
			mat_q  <= mat_d;
			dist_q <= dist_d;
			cnt_q  <= cnt_d;
			end_q  <= end_d;
		end
	end

	a_copy_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == lzbd_pkg::PH_COPY |-> mat_q != 32'd0)
		else $error("copy phase with no match bytes left");

	a_count_follows_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |=> cnt_q == $past(cnt_q) + 32'd1)
		else $error("output count did not advance on a history write");

	a_done_clears_lengths: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == lzbd_pkg::PH_DONE |-> lit_q == 32'd0 && mat_q == 32'd0)
		else $error("run lengths left over after end of block");

endmodule

>>> rtl/lz_block_decompressor.sv
// top level of the lz block decompressor: input register, decoder, history, result register
// depends on lzbd_pkg, lzbd_history, lzbd_core
//
//   channel  handshake            payload
//   input    in_valid / in_ready  command, in_byte, in_last
//   result   res_valid/res_ready  out_byte, out_valid, out_last, busy_res, status
//   config   cfg_valid/cfg_ready  cfg_data (output_limit)
//
// one transaction in, one transaction out; a new input is taken every cycle unless the result register stalls
// each item passes the input register, then is decoded into the result register
// the history read for an item is issued as it enters the input register, with
// a bypass from the byte written at the same edge, so a distance of one repeats
// a full result register with res_ready low stalls the input register; in_ready
// stays high while the input register can move on in the same cycle
// reset clears control state only; history holds garbage until written

module lz_block_decompressor (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [7:0]  in_byte,
	input  logic        in_last,

	output logic        res_valid,
	input  logic        res_ready,
	output logic [7:0]  out_byte,
	output logic        out_valid,
	output logic        out_last,
	output logic        busy_res,
	output logic [2:0]  status,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	// input register
	logic       valid_s1;
	logic       cmd_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// result register
	logic              res_valid_q;
	lzbd_pkg::result_t res_q;
	lzbd_pkg::result_t res_d;

	logic [31:0] output_limit_q;

	logic                 step;
	logic                 capture;
	lzbd_pkg::hist_wr_t   hist_wr;
	lzbd_pkg::hist_rd_t   hist_rd;
	lzbd_pkg::hist_addr_t rd_addr;
	logic [7:0]           rd_data;

	// decode fires when the result register is free or being emptied
	assign step     = valid_s1 && (!res_valid_q || res_ready);
	assign in_ready = !valid_s1 || step;
	assign capture  = in_valid && in_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_limit_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			output_limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			cmd_s1  <= command;
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	// history read for the captured item, addressed from the state it will see
	assign hist_rd.en   = capture;
	assign hist_rd.addr = rd_addr;

	lzbd_history u_history (
		.clk     (clk),
		.wr      (hist_wr),
		.rd      (hist_rd),
		.rd_data (rd_data)
	);

	lzbd_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.cmd          (cmd_s1),
		.in_byte      (byte_s1),
		.in_last      (last_s1),
		.output_limit (output_limit_q),
		.rd_data      (rd_data),
		.res          (res_d),
		.wr           (hist_wr),
		.rd_addr      (rd_addr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign out_byte  = res_q.data;
	assign out_valid = res_q.valid;
	assign out_last  = res_q.last;
	assign busy_res  = res_q.busy;
	assign status    = res_q.status;

	// a byte comes out only on a clean step or on a literal that ends truncated
	a_byte_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && out_valid |->
			res_q.status == lzbd_pkg::ST_OK || res_q.status == lzbd_pkg::ST_TRUNCATED)
		else $error("decompressed byte carried an error status");

	// every error other than a refused push ends the block
	a_error_ends_block: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_q.status == lzbd_pkg::ST_BAD_OFFSET
			|| res_q.status == lzbd_pkg::ST_TRUNCATED
			|| res_q.status == lzbd_pkg::ST_LIMIT) |-> out_last && !busy_res)
		else $error("error status without end of block");

	// a refused push never touches history
	a_refused_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		step && res_d.status == lzbd_pkg::ST_REFUSED |-> !hist_wr.en && res_d.busy)
		else $error("refused push changed state");

endmodule

>>> tb/sv/lzbd_tb_pkg.sv
// scoreboard for the lz block decompressor testbench: a cycle-free decoder of the
// sequence format that predicts every result, plus the queue of results still due
// depends on lzbd_pkg for phase, status and result types and the history depth

package lzbd_tb_pkg;

	class lz_output_tracker;
		bit [31:0]          out_limit;
		lzbd_pkg::phase_t   ph;
		bit [31:0]          lit_left;
		bit [31:0]          match_left;
		bit [31:0]          out_count;
		bit [15:0]          distance;
		bit                 input_done;
		bit [7:0]           hist_mem [lzbd_pkg::HISTORY_DEPTH];
		lzbd_pkg::result_t  cur;
		lzbd_pkg::result_t  due_results [$];
		int                 fails;
		int                 seen;

		function new();
			out_limit = '0;
			fails     = 0;
			seen      = 0;
			clear_block();
		endfunction

		function void clear_block();
			ph         = lzbd_pkg::PH_TOKEN;
			lit_left   = '0;
			match_left = '0;
			distance   = '0;
			out_count  = '0;
			input_done = 1'b0;
		endfunction

		function void set_limit(bit [31:0] v);
			out_limit = v;
		endfunction

		function bit copying();
			return ph == lzbd_pkg::PH_COPY;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		// length extension saturates at all ones
		function bit [31:0] grow(bit [31:0] a, bit [7:0] b);
			bit [32:0] s;
			s = {1'b0, a} + {25'b0, b};
			return s[32] ? 32'hFFFF_FFFF : s[31:0];
		endfunction

		function void end_block(lzbd_pkg::status_t s);
			ph         = lzbd_pkg::PH_DONE;
			lit_left   = '0;
			match_left = '0;
			cur.last   = 1'b1;
			cur.status = s;
		endfunction

		function void put_out(bit [7:0] b);
			hist_mem[lzbd_pkg::hist_addr_t'(out_count)] = b;
			out_count = out_count + 1;
			cur.data  = b;
			cur.valid = 1'b1;
		endfunction

		function void end_literals(bit last);
			if (last || out_count >= out_limit)
				end_block(lzbd_pkg::ST_OK);
			else
				ph = lzbd_pkg::PH_OFFLO;
		endfunction

		function void take_byte(bit [7:0] b, bit last);
			bit [3:0] lit_nib;
			case (ph)
				lzbd_pkg::PH_TOKEN: begin
					lit_nib    = b[7:4];
					match_left = lzbd_pkg::MIN_MATCH + {28'b0, b[3:0]};
					lit_left   = {28'b0, lit_nib};
					if (lit_nib == lzbd_pkg::NIBBLE_EXT) begin
						if (last) end_block(lzbd_pkg::ST_TRUNCATED);
						else ph = lzbd_pkg::PH_LITLEN;
					end else if (lit_nib == 4'h0) begin
						end_literals(last);
					end else begin
						if (last) end_block(lzbd_pkg::ST_TRUNCATED);
						else ph = lzbd_pkg::PH_LIT;
					end
				end
				lzbd_pkg::PH_LITLEN: begin
					lit_left = grow(lit_left, b);
					if (last) end_block(lzbd_pkg::ST_TRUNCATED);
					else if (b != lzbd_pkg::BYTE_EXT) ph = lzbd_pkg::PH_LIT;
				end
				lzbd_pkg::PH_LIT: begin
					if (out_count >= out_limit) begin
						end_block(lzbd_pkg::ST_LIMIT);
					end else begin
						put_out(b);
						lit_left = lit_left - 1;
						if (lit_left == 0) end_literals(last);
						else if (last) end_block(lzbd_pkg::ST_TRUNCATED);
					end
				end
				lzbd_pkg::PH_OFFLO: begin
					distance = {8'h00, b};
					if (last) end_block(lzbd_pkg::ST_TRUNCATED);
					else ph = lzbd_pkg::PH_OFFHI;
				end
				lzbd_pkg::PH_OFFHI: begin
					distance[15:8] = b;
					if (distance == 0 || {16'b0, distance} > out_count ||
							{16'b0, distance} > lzbd_pkg::HISTORY_DEPTH) begin
						end_block(lzbd_pkg::ST_BAD_OFFSET);
					end else if (match_left == lzbd_pkg::MATCH_EXT) begin
						if (last) end_block(lzbd_pkg::ST_TRUNCATED);
						else ph = lzbd_pkg::PH_MATLEN;
					end else begin
						ph         = lzbd_pkg::PH_COPY;
						input_done = last;
					end
				end
				lzbd_pkg::PH_MATLEN: begin
					match_left = grow(match_left, b);
					if (b != lzbd_pkg::BYTE_EXT) begin
						ph         = lzbd_pkg::PH_COPY;
						input_done = last;
					end else if (last) begin
						end_block(lzbd_pkg::ST_TRUNCATED);
					end
				end
				default: ;
			endcase
		endfunction

		function void take_tick();
			lzbd_pkg::hist_addr_t src;
			if (ph != lzbd_pkg::PH_COPY) return;
			if (out_count >= out_limit) begin
				end_block(lzbd_pkg::ST_LIMIT);
				return;
			end
			src = lzbd_pkg::hist_addr_t'(out_count - {16'b0, distance});
			put_out(hist_mem[src]);
			match_left = match_left - 1;
			if (match_left == 0) begin
				if (input_done) end_block(lzbd_pkg::ST_OK);
				else ph = lzbd_pkg::PH_TOKEN;
			end
		endfunction

		// one accepted input transaction gives exactly one result
		function void note_input(bit cmd, bit [7:0] b, bit last);
			cur = '0;
			if (!cmd) begin
				if (ph == lzbd_pkg::PH_COPY) begin
					cur.status = lzbd_pkg::ST_REFUSED;
				end else begin
					if (ph == lzbd_pkg::PH_DONE) clear_block();
					take_byte(b, last);
				end
			end else begin
				take_tick();
			end
			cur.busy = (ph == lzbd_pkg::PH_COPY);
			due_results = {due_results, cur};
		endfunction

		function void check_result(logic [7:0] data, logic valid, logic last, logic busy,
				logic [2:0] st);
			lzbd_pkg::result_t w;
			seen++;
			if (due_results.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("result %0d with nothing outstanding: byte=%02h status=%0d",
						seen, data, st);
				return;
			end
			w = due_results.pop_front();
			if (data !== w.data || valid !== w.valid || last !== w.last ||
					busy !== w.busy || st !== w.status) begin
				fails++;
				if (fails <= 10)
					$display({"result %0d: expected byte=%02h valid=%0b last=%0b busy=%0b ",
						"status=%0d, got byte=%02h valid=%0b last=%0b busy=%0b status=%0d"},
						seen, w.data, w.valid, w.last, w.busy, w.status,
						data, valid, last, busy, st);
			end
		endfunction

		function void flush_check();
			if (due_results.size() != 0) begin
				fails += due_results.size();
				$display("%0d results never arrived", due_results.size());
			end
		endfunction
	endclass

endpackage

>>> tb/sv/tb_lz_block_decompressor.sv
// self-checking testbench for lz_block_decompressor: directed sequences, then
// random compressed blocks under several output limits with random idling
// depends on lzbd_pkg, lzbd_tb_pkg and the lz_block_decompressor rtl

module tb_lz_block_decompressor;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_TICK = 1'b1;
	localparam int   PHASE_QUOTA = 212;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        command;
	logic [7:0]  in_byte;
	logic        in_last;
	logic        res_valid;
	logic        res_ready;
	logic [7:0]  out_byte;
	logic        out_valid;
	logic        out_last;
	logic        busy_res;
	logic [2:0]  status;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;

	lzbd_tb_pkg::lz_output_tracker board;

	// quiet turns off idling on both sides
	bit          quiet;
	int          work_items;
	logic [7:0]  code_q [$];
	logic [31:0] limit_set [8];

	lz_block_decompressor uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.out_byte  (out_byte),
		.out_valid (out_valid),
		.out_last  (out_last),
		.busy_res  (busy_res),
		.status    (status),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// generous cap, far above the slowest correct run
	initial begin
		#10ms;
		$display("FAIL lz_block_decompressor");
		$finish;
	end

	// receiver: random stalls except in the quiet stretch
	always @(posedge clk) begin
		res_ready <= quiet || ($urandom_range(99) >= 8);
	end

	// every result transaction is checked against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && board != null && res_valid && res_ready)
			board.check_result(out_byte, out_valid, out_last, busy_res, status);
	end

	// one input transaction; valid stays high afterwards so the caller can
	// chain the next item at the same edge
	task automatic send_item(input logic cmd, input logic [7:0] b, input logic last);
		if (!quiet && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		in_byte  <= b;
		in_last  <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.note_input(cmd, b, last);
	endtask

	// sender holds off until every predicted result has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// register write, only issued while the block is idle
	task automatic send_cfg(input logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.set_limit(v);
		cfg_valid <= 1'b0;
	endtask

	// appends one byte to the compressed stream
	function automatic void add_code(input logic [7:0] b);
		code_q = {code_q, b};
	endfunction

	// mostly short runs, sometimes exactly one nibble of 15, sometimes extended
	function automatic int pick_len();
		case ($urandom_range(9))
			0:       return 0;
			7:       return 15;
			8:       return $urandom_range(16, 40);
			9:       return $urandom_range(260, 300);
			default: return $urandom_range(1, 14);
		endcase
	endfunction

	// length extension bytes: 255 while more follows, then the remainder
	function automatic void put_ext(input int n);
		while (n >= 255) begin
			add_code(8'hFF);
			n -= 255;
		end
		add_code(8'(n));
	endfunction

	// well-formed block: match sequences, then a literal-only closing sequence;
	// with bad_off one offset is zero or reaches before the written output and
	// the block stops right there
	function automatic void build_block(input bit bad_off);
		int nseq;
		int bad_at;
		int lit_n;
		int mat_n;
		int back_off;
		int produced;
		code_q.delete();
		produced = 0;
		nseq     = $urandom_range(bad_off ? 1 : 0, 4);
		bad_at   = bad_off ? $urandom_range(0, nseq - 1) : -1;
		for (int i = 0; i < nseq; i++) begin
			lit_n = pick_len();
			if (produced == 0 && lit_n == 0) lit_n = 1;
			mat_n = pick_len() + 4;
			add_code({(lit_n >= 15) ? 4'hF : 4'(lit_n),
				(mat_n - 4 >= 15) ? 4'hF : 4'(mat_n - 4)});
			if (lit_n >= 15) put_ext(lit_n - 15);
			repeat (lit_n) add_code(8'($urandom));
			produced += lit_n;
			if (i == bad_at)
				back_off = $urandom_range(1) ? 0 : $urandom_range(produced + 1, 65535);
			else if ($urandom_range(1))
				back_off = $urandom_range(1, (produced < 8) ? produced : 8);
			else
				back_off = $urandom_range(1, (produced < 65535) ? produced : 65535);
			add_code(8'(back_off));
			add_code(8'(back_off >> 8));
			if (i == bad_at) return;
			if (mat_n - 4 >= 15) put_ext(mat_n - 19);
			produced += mat_n;
		end
		lit_n = pick_len();
		add_code({(lit_n >= 15) ? 4'hF : 4'(lit_n), 4'h0});
		if (lit_n >= 15) put_ext(lit_n - 15);
		repeat (lit_n) add_code(8'($urandom));
	endfunction

	// feed code_q, ticking whenever the block is copying; a truncated block
	// puts in_last on a random byte and stops there; a little noise is mixed
	// in: pushes while copying and ticks while not
	task automatic stream_block(input bit trunc, input bit counted);
		int cut;
		int idx;
		cut = trunc ? $urandom_range(0, code_q.size() - 1) : code_q.size() - 1;
		idx = 0;
		while (idx <= cut) begin
			if (board.copying()) begin
				if ($urandom_range(99) < 4) begin
					send_item(CMD_PUSH, 8'($urandom), 1'($urandom));
				end else begin
					send_item(CMD_TICK, 8'($urandom), 1'($urandom));
					if (counted) work_items++;
				end
			end else if ($urandom_range(99) < 3) begin
				send_item(CMD_TICK, 8'($urandom), 1'($urandom));
			end else begin
				send_item(CMD_PUSH, code_q[idx], idx == cut);
				idx++;
				if (counted) work_items++;
			end
		end
		while (board.copying()) begin
			send_item(CMD_TICK, 8'($urandom), 1'($urandom));
			if (counted) work_items++;
		end
	endtask

	task automatic run_phase();
		int pick;
		work_items = 0;
		while (work_items < PHASE_QUOTA) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				build_block(1'b0);
				stream_block(1'b0, 1'b1);
			end else if (pick < 85) begin
				build_block(1'b0);
				stream_block(1'b1, 1'b1);
			end else begin
				build_block(1'b1);
				stream_block(1'b0, 1'b1);
			end
		end
	endtask

	// hand-picked items: idle tick, overlapping copy, refused push, end on a
	// bare token, truncation on a token and on a literal, zero offset and an
	// offset past the written output, tick after the block ended
	task automatic directed();
		send_item(CMD_TICK, 8'h00, 1'b0);
		send_item(CMD_PUSH, 8'h10, 1'b0);
		send_item(CMD_PUSH, 8'hFF, 1'b0);
		send_item(CMD_PUSH, 8'h01, 1'b0);
		send_item(CMD_PUSH, 8'h00, 1'b0);
		send_item(CMD_PUSH, 8'hA5, 1'b1);
		repeat (4) send_item(CMD_TICK, 8'hFF, 1'b1);
		send_item(CMD_PUSH, 8'h00, 1'b1);
		send_item(CMD_PUSH, 8'hF0, 1'b1);
		send_item(CMD_PUSH, 8'h20, 1'b0);
		send_item(CMD_PUSH, 8'h5A, 1'b1);
		send_item(CMD_PUSH, 8'h1F, 1'b0);
		send_item(CMD_PUSH, 8'h00, 1'b0);
		send_item(CMD_PUSH, 8'h00, 1'b0);
		send_item(CMD_PUSH, 8'h00, 1'b0);
		send_item(CMD_PUSH, 8'h10, 1'b0);
		send_item(CMD_PUSH, 8'h33, 1'b0);
		send_item(CMD_PUSH, 8'h02, 1'b0);
		send_item(CMD_PUSH, 8'h00, 1'b0);
		send_item(CMD_TICK, 8'h00, 1'b0);
	endtask

	initial begin
		board = new();
		quiet = 1'b0;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		command   <= CMD_PUSH;
		in_byte   <= 8'h00;
		in_last   <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data  <= 32'h0;

		// output limits per random phase: extremes, small ones that clip often,
		// and arbitrary values
		limit_set[0] = 32'h0000_0000;
		limit_set[1] = 32'hFFFF_FFFF;
		limit_set[2] = $urandom_range(1, 60);
		limit_set[3] = $urandom;
		limit_set[4] = 32'hFFFF_FFFF;
		limit_set[5] = $urandom_range(20, 200);
		limit_set[6] = 32'h0000_0001;
		limit_set[7] = 32'hFFFF_FFFF;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_cfg(32'hFFFF_FFFF);
		directed();
		drain();

		for (int p = 0; p < 8; p++) begin
			send_cfg(limit_set[p]);
			// phase 4 is the stretch without any idling
			quiet = (p == 4);
			run_phase();
			drain();
		end

		board.flush_check();
		if (board.fails == 0)
			$display("PASS lz_block_decompressor");
		else
			$display("FAIL lz_block_decompressor");
		$finish;
	end

endmodule

>>> files.f
rtl/lzbd_pkg.sv
rtl/lzbd_history.sv
rtl/lzbd_core.sv
rtl/lz_block_decompressor.sv
tb/sv/lzbd_tb_pkg.sv
tb/sv/tb_lz_block_decompressor.sv
